/* rtl/assert_macros.svh */
// Assertion macros used by the RTL of the LRU frame table.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("immediate implication failed");

`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

/* rtl/lrupr_pkg.sv */
// Package of the LRU frame table: word types, cell commands, state codes and defaults.
// Used by the cell, the top level and the testbench.
package lrupr_pkg;

	localparam int FRAMES_DEF    = 8;
	localparam int PAGE_BITS_DEF = 16;
	localparam int PAGE_W        = 16;
	localparam int INDEX_W       = 3;
	localparam int COUNT_W       = 32;
	localparam int CAP_W         = 4;
	localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

	typedef struct packed {
		logic [PAGE_W-1:0] page_number;
	} page_word_t;

	typedef struct packed {
		logic               hit;
		logic [INDEX_W-1:0] frame_index;
		logic [COUNT_W-1:0] fault_count;
	} result_word_t;

	typedef struct packed {
		logic [CAP_W-1:0] frames_in_use;
	} cfg_word_t;

	typedef struct packed {
		logic clear;
		logic commit;
		logic hit;
		logic full;
	} cell_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_UPDATE
	} lrupr_state_t;

endpackage

/* rtl/lrupr_word_if.sv */
// Valid/ready channel that moves one word of type T per handshake.
// The word types come from lrupr_pkg.
interface lrupr_word_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* rtl/lrupr_cell.sv */
// One frame of the LRU table: stored page, valid bit and recency rank.
// Takes its commands from the top level and the valid bit of its left neighbor; uses lrupr_pkg.
module lrupr_cell #(
	parameter int FRAMES    = 8,
	parameter int PAGE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lrupr_pkg::cell_cmd_t          cmd,
	input  logic [PAGE_BITS-1:0]          key,
	input  logic [$clog2(FRAMES)-1:0]     hit_rank,
	input  logic [$clog2(FRAMES)-1:0]     last_rank,
	input  logic                          prev_valid,
	output logic                          valid,
	output logic                          match_s1,
	output logic [$clog2(FRAMES)-1:0]     rank,
	output logic                          pick
);
	import lrupr_pkg::*;

	localparam int RW = $clog2(FRAMES);

	logic [PAGE_BITS-1:0] page_q;
	logic                 valid_q;
	logic [RW-1:0]        rank_q;

	assign valid = valid_q;
	assign rank  = rank_q;

	always_comb begin
		if (cmd.hit) begin
			pick = match_s1;
		end else if (cmd.full) begin
			pick = valid_q && (rank_q == last_rank);
		end else begin
			pick = prev_valid && !valid_q;
		end
	end

	always_ff @(posedge clk) begin
		match_s1 <= valid_q && (page_q == key);
		if (cmd.commit && pick && !cmd.hit) begin
			page_q <= key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else if (cmd.clear) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else if (cmd.commit) begin
			if (pick) begin
				valid_q <= 1'b1;
				rank_q  <= '0;
			end else if (valid_q && (!cmd.hit || rank_q < hit_rank)) begin
				rank_q <= rank_q + RW'(1);
			end
		end
	end

endmodule

/* rtl/lru_page_replacement.sv */
// LRU page replacement table: an accepted page word is registered as the key and compared
// in every frame cell in ST_LOOKUP; ST_UPDATE updates the recency ranks and writes the result
// register, waiting while that register is full and not read, and takes the next page word.
// Reset empties all frames, zeroes the fault counter and sets frames_in_use to 8.
// A configuration write clears the table and the counter in the cycle it is taken.
module lru_page_replacement #(
	parameter int FRAMES    = lrupr_pkg::FRAMES_DEF,
	parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	lrupr_word_if.sink  page,
	lrupr_word_if.source result,
	lrupr_word_if.sink  cfg
);
	import lrupr_pkg::*;

	`include "assert_macros.svh"

	localparam int RW = $clog2(FRAMES);
	localparam int CW = $clog2(FRAMES + 1);

	lrupr_state_t state_q, state_d;

	logic [CAP_W-1:0]     fiu_q;
	logic [CW-1:0]        cap;
	logic [CW-1:0]        filled_q;
	logic [COUNT_W-1:0]   faults_q, faults_d;
	logic [PAGE_BITS-1:0] key_q;
	logic                 out_valid_q;
	result_word_t         out_q;

	cell_cmd_t            cmd;
	logic                 can_write;
	logic                 cfg_write;
	logic                 hit;
	logic [RW-1:0]        hit_rank;
	logic [RW-1:0]        last_rank;
	logic [RW-1:0]        pick_idx;

	logic [FRAMES-1:0]    valid_w;
	logic [FRAMES-1:0]    match_w;
	logic [FRAMES-1:0]    pick_w;
	logic [RW-1:0]        rank_w [FRAMES];

	assign cfg.ready     = 1'b1;
	assign cfg_write     = cfg.valid;
	assign can_write     = !out_valid_q || result.ready;
	assign result.valid  = out_valid_q;
	assign result.data   = out_q;

	always_comb begin
		if (fiu_q == '0) begin
			cap = CW'(1);
		end else if (int'(fiu_q) > FRAMES) begin
			cap = CW'(FRAMES);
		end else begin
			cap = CW'(fiu_q);
		end
	end

	assign last_rank = RW'(filled_q - CW'(1));
	assign hit       = |match_w;

	always_comb begin
		hit_rank = '0;
		pick_idx = '0;
		for (int i = 0; i < FRAMES; i++) begin
			if (match_w[i]) begin
				hit_rank |= rank_w[i];
			end
			if (pick_w[i]) begin
				pick_idx |= RW'(i);
			end
		end
	end

	always_comb begin
		cmd.clear  = cfg_write;
		cmd.commit = (state_q == ST_UPDATE) && can_write;
		cmd.hit    = hit;
		cmd.full   = filled_q >= cap;
	end

	always_comb begin
		faults_d = faults_q;
		if (!hit && faults_q != '1) begin
			faults_d = faults_q + COUNT_W'(1);
		end
	end

	always_comb begin
		state_d    = state_q;
		page.ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				page.ready = 1'b1;
				if (page.valid) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				page.ready = can_write;
				if (can_write) begin
					state_d = page.valid ? ST_LOOKUP : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (page.valid && page.ready) begin
			key_q <= PAGE_BITS'(page.data.page_number);
		end
		if (cmd.commit) begin
			out_q.hit         <= hit;
			out_q.frame_index <= INDEX_W'(pick_idx);
			out_q.fault_count <= faults_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fiu_q       <= CAP_RESET;
			filled_q    <= '0;
			faults_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				fiu_q    <= cfg.data.frames_in_use;
				filled_q <= '0;
				faults_q <= '0;
			end else if (cmd.commit) begin
				faults_q <= faults_d;
				if (!hit && !cmd.full) begin
					filled_q <= filled_q + CW'(1);
				end
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	for (genvar g = 0; g < FRAMES; g++) begin : g_cell
		lrupr_cell #(
			.FRAMES    (FRAMES),
			.PAGE_BITS (PAGE_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.key        (key_q),
			.hit_rank   (hit_rank),
			.last_rank  (last_rank),
			.prev_valid ((g == 0) ? 1'b1 : valid_w[(g == 0) ? 0 : g - 1]),
			.valid      (valid_w[g]),
			.match_s1   (match_w[g]),
			.rank       (rank_w[g]),
			.pick       (pick_w[g])
		);
	end

	`ASSERT_IMPL(a_single_match, state_q == ST_UPDATE, $onehot0(match_w))
	`ASSERT_IMPL(a_single_pick, cmd.commit, $onehot(pick_w))
	`ASSERT_IMPL(a_fill_count, 1'b1, $countones(valid_w) == int'(filled_q))
	`ASSERT_NEXT(a_result_after_commit, cmd.commit, out_valid_q)

endmodule

/* tb/tb_lru_page_replacement.sv */
// Self-checking testbench for the LRU page replacement table.
// It drives page words and frames_in_use writes, predicts every result word and compares them.
// Depends on lrupr_pkg, lrupr_word_if and lru_page_replacement.
module tb_lru_page_replacement;
	timeunit 1ns;
	timeprecision 1ps;

	import lrupr_pkg::*;

	localparam int NFR = FRAMES_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int ITEMS_PER_SETTING = 102;

	logic clk = 1'b0;
	logic arst_n;

	always #5 clk = ~clk;

	lrupr_word_if #(.T(page_word_t))   page_if ();
	lrupr_word_if #(.T(result_word_t)) res_if ();
	lrupr_word_if #(.T(cfg_word_t))    cfg_if ();

	lru_page_replacement uut (
		.clk(clk),
		.arst_n(arst_n),
		.page(page_if),
		.result(res_if),
		.cfg(cfg_if)
	);

	logic [PAGE_W-1:0]  tbl_page [NFR];
	logic [INDEX_W-1:0] tbl_rank [NFR];
	int unsigned        tbl_filled;
	int unsigned        tbl_faults;
	logic [CAP_W-1:0]   cap_reg;

	logic [PAGE_W-1:0] page_backlog [$];
	result_word_t      awaited [$];

	bit page_taken = 1'b0;
	bit idle_on = 1'b1;
	int send_gap = 0;
	int stall_left = 0;
	int errors = 0;
	int cycles = 0;
	int pages_sent = 0;
	int hit_total = 0;
	int fault_total = 0;
	int cfg_writes = 0;

	function automatic void clear_table();
		for (int i = 0; i < NFR; i++) begin
			tbl_rank[i] = '0;
		end
		tbl_filled = 0;
		tbl_faults = 0;
	endfunction

	// Frame f becomes the most recent; filled frames ranked below lim move back one place.
	function automatic void age_ranks(int unsigned f, int unsigned lim);
		for (int unsigned i = 0; i < tbl_filled; i++) begin
			if (i != f && tbl_rank[i] < lim)
				tbl_rank[i] = tbl_rank[i] + 1'b1;
		end
		tbl_rank[f] = '0;
	endfunction

	function automatic result_word_t lru_lookup(logic [PAGE_W-1:0] pg);
		result_word_t r;
		int unsigned cap;
		int unsigned fr;
		logic found;
		cap = (cap_reg == 0) ? 1 : (cap_reg > NFR) ? NFR : cap_reg;
		found = 1'b0;
		fr = 0;
		for (int unsigned i = 0; i < tbl_filled; i++) begin
			if (!found && tbl_page[i] == pg) begin
				found = 1'b1;
				fr = i;
			end
		end
		if (found) begin
			age_ranks(fr, tbl_rank[fr]);
		end else begin
			if (tbl_faults != 32'hFFFF_FFFF)
				tbl_faults++;
			if (tbl_filled < cap) begin
				fr = tbl_filled;
				tbl_page[fr] = pg;
				age_ranks(fr, 32'hFFFF_FFFF);
				tbl_filled++;
			end else begin
				fr = 0;
				for (int unsigned i = 1; i < tbl_filled; i++) begin
					if (tbl_rank[i] > tbl_rank[fr])
						fr = i;
				end
				tbl_page[fr] = pg;
				age_ranks(fr, tbl_rank[fr]);
			end
		end
		r.hit = found;
		r.frame_index = fr[INDEX_W-1:0];
		r.fault_count = tbl_faults;
		return r;
	endfunction

	always @(posedge clk) begin : monitor
		result_word_t want;
		result_word_t seen;
		page_taken = arst_n && page_if.valid && page_if.ready;
		if (page_taken) begin
			awaited.insert(awaited.size(), lru_lookup(page_if.data.page_number));
			pages_sent++;
		end
		if (arst_n && res_if.valid && res_if.ready) begin
			seen = res_if.data;
			if (seen.hit)
				hit_total++;
			else
				fault_total++;
			if (awaited.size() == 0) begin
				$error("result word arrived with no page word pending");
				errors++;
			end else begin
				want = awaited.pop_front();
				if (seen.hit !== want.hit) begin
					$error("hit: expected %0d, got %0d", want.hit, seen.hit);
					errors++;
				end
				if (seen.frame_index !== want.frame_index) begin
					$error("frame_index: expected %0d, got %0d",
						want.frame_index, seen.frame_index);
					errors++;
				end
				if (seen.fault_count !== want.fault_count) begin
					$error("fault_count: expected %0d, got %0d",
						want.fault_count, seen.fault_count);
					errors++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (!page_if.valid || page_taken) begin
			if (send_gap > 0) begin
				send_gap--;
				page_if.valid <= 1'b0;
			end else if (page_backlog.size() == 0) begin
				page_if.valid <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				send_gap = $urandom_range(0, 4);
				page_if.valid <= 1'b0;
			end else begin
				page_if.valid <= 1'b1;
				page_if.data <= page_backlog.pop_front();
			end
		end
	end

	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			res_if.ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 6) == 0) begin
			stall_left = $urandom_range(0, 4);
			res_if.ready <= 1'b0;
		end else begin
			res_if.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[lru_page_replacement] ERROR");
			$finish;
		end
	end

	task automatic wait_drained();
		while (page_backlog.size() != 0 || page_if.valid || awaited.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(logic [CAP_W-1:0] v);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.data <= v;
		do
			@(posedge clk);
		while (!cfg_if.ready);
		cap_reg = v;
		clear_table();
		cfg_writes++;
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	initial begin
		logic [CAP_W-1:0] plan [$];
		logic [PAGE_W-1:0] pool [$];
		logic [PAGE_W-1:0] pg;
		int cap_eff;
		int pick;
		arst_n = 1'b0;
		page_if.valid = 1'b0;
		page_if.data = '0;
		res_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.data = '0;
		cap_reg = CAP_RESET;
		clear_table();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset capacity: fill all frames, hit the two oldest pages, then evict.
		page_backlog = '{16'h0000, 16'hFFFF, 16'h0001, 16'h0002, 16'h0003, 16'h0004,
			16'h0005, 16'h0006, 16'hFFFF, 16'h0000, 16'h0007, 16'h0001, 16'h8000,
			16'h5555};
		wait_drained();

		// A single frame, then a capacity of zero, which behaves as one frame.
		cfg_write(4'd1);
		page_backlog = '{16'hAAAA, 16'hAAAA, 16'h0006, 16'hAAAA};
		wait_drained();
		cfg_write(4'd0);
		page_backlog = '{16'h0003, 16'h0003, 16'h0004};
		wait_drained();

		plan = '{4'd15, 4'd2, 4'd8, 4'd9, 4'd4, 4'd3, 4'd6, 4'd7, 4'd10, 4'd5, 4'd13, 4'd1,
			4'd12, 4'd8};
		plan.insert(6, CAP_W'($urandom_range(0, 15)));
		plan.insert(11, CAP_W'($urandom_range(0, 15)));
		foreach (plan[k]) begin
			idle_on = (k != plan.size() - 1) && (k % 4 != 3);
			cfg_write(plan[k]);
			cap_eff = (plan[k] == 0) ? 1 : (plan[k] > NFR) ? NFR : plan[k];
			pool.delete();
			repeat (cap_eff + $urandom_range(0, 3))
				pool.insert(pool.size(), PAGE_W'($urandom_range(0, 65535)));
			repeat (ITEMS_PER_SETTING) begin
				pick = $urandom_range(0, 99);
				if (pick < 80) begin
					pg = pool[$urandom_range(0, pool.size() - 1)];
				end else if (pick < 90) begin
					pg = PAGE_W'($urandom_range(0, 65535));
					pool[$urandom_range(0, pool.size() - 1)] = pg;
				end else begin
					pg = PAGE_W'($urandom_range(0, 65535));
				end
				page_backlog.insert(page_backlog.size(), pg);
			end
			wait_drained();
		end

		repeat (10) @(posedge clk);
		$display("Sent %0d page words: %0d hits and %0d faults checked.",
			pages_sent, hit_total, fault_total);
		$display("Covered %0d frames_in_use writes, including zero and values above %0d.",
			cfg_writes, NFR);
		if (errors == 0 && awaited.size() == 0) begin
			$display("[lru_page_replacement] OK");
		end else begin
			$display("[lru_page_replacement] ERROR");
		end
		$finish;
	end
endmodule
